// ===== rtl/core/bvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvs_pkg
// Shared types and constants of the bounded value store.
// ----------------------------------------------------------------------------
package bvs_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam int OUT_CNT_W = 5;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [ACT_W-1:0] ACT_PUT    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/bvs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvs_cell
// One slot of the store: holds one entry, loads a new entry or takes the
// entry of its upper neighbour.
// ----------------------------------------------------------------------------
module bvs_cell
  import bvs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire cell_ctrl_t        ctrl_i,
  input  wire logic [DATA_W-1:0] nbr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  output logic      [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      data_q <= wr_data_i;
    end else if (ctrl_i.shift) begin
      data_q <= nbr_i;
    end
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// ===== rtl/core/bounded_value_store_min_max_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_value_store_min_max_top
// Packed store of signed values with put, delete-all-equal and clear, and a
// min/max report after every command.
// ----------------------------------------------------------------------------
// Usage: raise start_i with action_i and value_i while busy_o is low. The
// entries sit in a row of DEPTH cells. Each command is followed by one pass
// over the row in which the row shifts down by one cell a cycle; the
// entry leaving the bottom cell is checked, kept entries are written back
// higher up the row so that they end packed in order, and min and max are
// gathered from them. done_o pulses for one cycle, registered after the
// last step of the pass, with status, count and min/max; the receiver cannot
// stall, so capture the result on that cycle. A new command may be given on
// the done_o cycle.
// The capacity register may only be written while busy_o is low.
// ----------------------------------------------------------------------------
module bounded_value_store_min_max_top
  import bvs_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CAP_W-1:0]         cfg_wdata_i,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [ACT_W-1:0]         action_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          done_o,
  output logic      [STAT_W-1:0]        status_o,
  output logic      [OUT_CNT_W-1:0]     count_o,
  output logic signed [DATA_W-1:0]      min_value_o,
  output logic signed [DATA_W-1:0]      max_value_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PASS = 1'b1;

  logic              state_q, state_d;
  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  pass_q, pass_d;
  logic [CNT_W-1:0]  kept_q, kept_d;
  logic              have_q, have_d;
  logic [DATA_W-1:0] min_q, min_d, max_q, max_d;
  logic [ACT_W-1:0]  act_q;
  logic [DATA_W-1:0] val_q;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic              done_q;
  logic [STAT_W-1:0] status_q;
  logic [CNT_W-1:0]  res_count_q;
  logic [DATA_W-1:0] res_min_q, res_max_q;

  logic              accept;
  logic [CNT_W-1:0]  usable;
  logic [DATA_W-1:0] head;
  logic              present;
  logic              keep;
  logic [IDX_W-1:0]  wr_idx;
  logic              wr_en;
  logic [DATA_W-1:0] wr_data;
  logic              last;

  cell_ctrl_t        ctrl [DEPTH];
  logic [DATA_W-1:0] cell_data [DEPTH];

  assign accept = start_i && (state_q == ST_IDLE);
  assign usable = (32'(cap_q) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_q);
  assign head   = cell_data[0];
  assign present = (CNT_W'(pass_q) < count_q);
  assign keep   = (state_q == ST_PASS) && present &&
                  !((act_q == ACT_DELETE) && (head == val_q));
  assign last   = (pass_q == IDX_W'(DEPTH - 1));

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pass_d  = pass_q;
    kept_d  = kept_q;
    have_d  = have_q;
    min_d   = min_q;
    max_d   = max_q;
    stat_d  = stat_q;
    wr_en   = 1'b0;
    wr_idx  = count_q[IDX_W-1:0];
    wr_data = value_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_PASS;
          pass_d  = '0;
          kept_d  = '0;
          have_d  = 1'b0;
          stat_d  = STAT_OK;
          priority if (action_i == ACT_PUT) begin
            if (count_q >= usable) begin
              stat_d = STAT_FULL;
            end else begin
              wr_en   = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end else if (action_i == ACT_DELETE) begin
            if (count_q == '0) begin
              stat_d = STAT_EMPTY;
            end
          end else if (action_i == ACT_CLEAR) begin
            count_d = '0;
          end else begin
            stat_d = STAT_OK;
          end
        end
      end
      ST_PASS: begin
        wr_data = head;
        wr_idx  = IDX_W'(kept_q) + IDX_W'(DEPTH - 1) - pass_q;
        if (keep) begin
          wr_en  = 1'b1;
          kept_d = kept_q + CNT_W'(1);
          have_d = 1'b1;
          if (!have_q || ($signed(head) < $signed(min_q))) begin
            min_d = head;
          end
          if (!have_q || ($signed(head) > $signed(max_q))) begin
            max_d = head;
          end
        end
        pass_d = pass_q + IDX_W'(1);
        if (last) begin
          state_d = ST_IDLE;
          count_d = kept_d;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] nbr;
    if (i == DEPTH - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_data[i + 1];
    end
    assign ctrl[i].shift = (state_q == ST_PASS);
    assign ctrl[i].wr    = wr_en && (wr_idx == IDX_W'(i));
    bvs_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl[i]),
      .nbr_i     (nbr),
      .wr_data_i (wr_data),
      .data_o    (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= CAP_RESET;
      count_q <= '0;
      pass_q  <= '0;
      kept_q  <= '0;
      have_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pass_q  <= pass_d;
      kept_q  <= kept_d;
      have_q  <= have_d;
      done_q  <= (state_q == ST_PASS) && last;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    min_q  <= min_d;
    max_q  <= max_d;
    stat_q <= stat_d;
    if (accept) begin
      act_q <= action_i;
      val_q <= value_i;
    end
    if ((state_q == ST_PASS) && last) begin
      status_q    <= stat_q;
      res_count_q <= kept_d;
      res_min_q   <= have_d ? min_d : '0;
      res_max_q   <= have_d ? max_d : '0;
    end
  end

  assign busy_o      = (state_q == ST_PASS);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign count_o     = OUT_CNT_W'(32'(res_count_q));
  assign min_value_o = res_min_q;
  assign max_value_o = res_max_q;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded value store with min/max report. A
// driver feeds put, delete, clear and unused-code commands from a queue with
// random gaps. Capacity writes are made only while the store is idle. A
// monitor predicts every report from its own copy of the store and compares
// status, count, minimum and maximum.
// ----------------------------------------------------------------------------
module tb_top;
  import bvs_pkg::*;

  localparam int LIMIT         = 500000;
  localparam int SETTLE_CYCLES = 4 * (DEPTH + 1);
  localparam int RANDOM_ITEMS  = 1620;
  localparam int MAX_SHOWN     = 10;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef enum logic [1:0] {STEP_CMD, STEP_CAP, STEP_DRAIN} step_kind_e;

  typedef struct packed {
    step_kind_e                 kind;
    logic [ACT_W-1:0]           action;
    logic signed [DATA_W-1:0]   value;
    logic [CAP_W-1:0]           cap;
    logic [4:0]                 gap;
  } step_t;

  typedef struct packed {
    logic [STAT_W-1:0]          status;
    logic [OUT_CNT_W-1:0]       count;
    logic signed [DATA_W-1:0]   min_value;
    logic signed [DATA_W-1:0]   max_value;
  } report_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CAP_W-1:0]         cfg_wdata_i = '0;
  logic                     start_i     = 1'b0;
  logic [ACT_W-1:0]         action_i    = '0;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     busy_o;
  logic                     done_o;
  logic [STAT_W-1:0]        status_o;
  logic [OUT_CNT_W-1:0]     count_o;
  logic signed [DATA_W-1:0] min_value_o;
  logic signed [DATA_W-1:0] max_value_o;

  bounded_value_store_min_max_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .action_i    (action_i),
    .value_i     (value_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .min_value_o (min_value_o),
    .max_value_o (max_value_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the store
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int                       shadow_fill = 0;
  logic [CAP_W-1:0]         shadow_cap  = CAP_RESET;

  step_t   pending_steps [$];
  report_t owed_reports  [$];

  int n_launched   = 0;
  int n_accepted   = 0;
  int n_mismatch   = 0;
  int n_cap_writes = 0;
  int n_full       = 0;
  int n_empty      = 0;
  int peak_count   = 0;
  int n_by_action [4] = '{default: 0};
  int cycles       = 0;

  function automatic report_t store_command(input logic [ACT_W-1:0] act,
                                            input logic signed [DATA_W-1:0] v);
    report_t r;
    int      slots;
    int      kept;
    r.status = STAT_OK;
    slots = (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
    case (act)
      ACT_PUT: begin
        if (shadow_fill >= slots) begin
          r.status = STAT_FULL;
        end else begin
          shadow_entries[shadow_fill] = v;
          shadow_fill++;
        end
      end
      ACT_DELETE: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          kept = 0;
          for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_entries[i] != v) begin
              shadow_entries[kept] = shadow_entries[i];
              kept++;
            end
          end
          shadow_fill = kept;
        end
      end
      ACT_CLEAR: begin
        shadow_fill = 0;
      end
      default: ;
    endcase
    r.count     = OUT_CNT_W'(shadow_fill);
    r.min_value = '0;
    r.max_value = '0;
    if (shadow_fill > 0) begin
      r.min_value = shadow_entries[0];
      r.max_value = shadow_entries[0];
      for (int i = 1; i < shadow_fill; i++) begin
        if ($signed(shadow_entries[i]) < $signed(r.min_value)) begin
          r.min_value = shadow_entries[i];
        end
        if ($signed(shadow_entries[i]) > $signed(r.max_value)) begin
          r.max_value = shadow_entries[i];
        end
      end
    end
    return r;
  endfunction

  function automatic bit store_idle();
    return owed_reports.size() == 0 && n_accepted == n_launched && !busy_o;
  endfunction

  task automatic queue_cmd(input logic [ACT_W-1:0] a, input logic signed [DATA_W-1:0] v,
                           input int gap);
    step_t s;
    s.kind   = STEP_CMD;
    s.action = a;
    s.value  = v;
    s.cap    = '0;
    s.gap    = 5'(gap);
    pending_steps.push_back(s);
  endtask

  task automatic queue_cap(input logic [CAP_W-1:0] c);
    step_t s;
    s        = '0;
    s.kind   = STEP_CAP;
    s.cap    = c;
    pending_steps.push_back(s);
  endtask

  task automatic queue_drain();
    step_t s;
    s      = '0;
    s.kind = STEP_DRAIN;
    pending_steps.push_back(s);
  endtask

  task automatic note_mismatch(input string what, input report_t want, input report_t seen);
    n_mismatch++;
    if (n_mismatch <= MAX_SHOWN) begin
      $display("%0t: %s: expected status %0d count %0d min %0d max %0d,",
               $time, what, want.status, want.count, $signed(want.min_value),
               $signed(want.max_value));
      $display("    got status %0d count %0d min %0d max %0d",
               seen.status, seen.count, $signed(seen.min_value), $signed(seen.max_value));
    end
  endtask

  // Driver: inputs change on the falling edge
  int idle_left = 0;
  bit armed     = 1'b0;

  always @(negedge clk_i) begin
    logic  go;
    logic  we;
    step_t head;
    if (rst_ni) begin
      go = start_i;
      we = 1'b0;
      if (start_i && n_accepted == n_launched) go = 1'b0;
      if (!go && pending_steps.size() > 0) begin
        head = pending_steps[0];
        case (head.kind)
          STEP_CMD: begin
            if (!armed) begin
              idle_left = head.gap;
              armed     = 1'b1;
            end
            if (idle_left > 0) begin
              idle_left--;
            end else begin
              go        = 1'b1;
              action_i <= head.action;
              value_i  <= head.value;
              n_launched++;
              armed     = 1'b0;
              void'(pending_steps.pop_front());
            end
          end
          STEP_CAP: begin
            if (store_idle()) begin
              we           = 1'b1;
              cfg_wdata_i <= head.cap;
              void'(pending_steps.pop_front());
            end
          end
          default: begin
            if (store_idle()) void'(pending_steps.pop_front());
          end
        endcase
      end
      start_i  <= go;
      cfg_we_i <= we;
    end
  end

  // Monitor: sample on the rising edge
  always @(posedge clk_i) begin
    report_t seen;
    report_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        shadow_cap = cfg_wdata_i;
        n_cap_writes++;
      end
      if (done_o) begin
        seen.status    = status_o;
        seen.count     = count_o;
        seen.min_value = min_value_o;
        seen.max_value = max_value_o;
        if (owed_reports.size() == 0) begin
          note_mismatch("report with no command outstanding", '0, seen);
        end else begin
          want = owed_reports.pop_front();
          if (seen.status !== want.status || seen.count !== want.count ||
              seen.min_value !== want.min_value || seen.max_value !== want.max_value)
            note_mismatch("report mismatch", want, seen);
          if (want.status == STAT_FULL) n_full++;
          if (want.status == STAT_EMPTY) n_empty++;
          if (int'(want.count) > peak_count) peak_count = want.count;
        end
      end
      if (start_i && !busy_o) begin
        owed_reports.push_back(store_command(action_i, value_i));
        n_by_action[action_i]++;
        n_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic signed [DATA_W-1:0] pool [6];
    logic [ACT_W-1:0]         act;
    logic signed [DATA_W-1:0] v;
    logic [CAP_W-1:0]         cap;
    int                       made;
    int                       phase;
    int                       plen;
    int                       put_pct;
    int                       gap_mode;
    int                       gap;
    int                       r;

    queue_cap(5'd16);
    queue_cmd(ACT_DELETE, 0, 0);
    queue_cmd(ACT_UNUSED, 5, 0);
    queue_cmd(ACT_PUT, 32'h8000_0000, 0);
    queue_cmd(ACT_PUT, 32'h7fff_ffff, 3);
    queue_cmd(ACT_PUT, 0, 0);
    queue_cmd(ACT_PUT, -1, 0);
    queue_cmd(ACT_DELETE, 12345, 0);
    queue_cmd(ACT_DELETE, -1, 18);
    queue_cmd(ACT_PUT, 7, 0);
    queue_cmd(ACT_PUT, 7, 0);
    queue_cmd(ACT_PUT, 7, 0);
    queue_cmd(ACT_DELETE, 7, 0);
    queue_cmd(ACT_UNUSED, 0, 0);
    queue_cmd(ACT_CLEAR, 0, 0);
    queue_cap(5'd2);
    queue_cmd(ACT_PUT, 5, 0);
    queue_cmd(ACT_PUT, -5, 0);
    queue_cmd(ACT_PUT, 9, 0);
    // lower the capacity under the fill level
    queue_cap(5'd1);
    queue_cmd(ACT_PUT, 3, 0);
    queue_cmd(ACT_DELETE, 5, 0);
    queue_cmd(ACT_PUT, 3, 0);
    queue_cmd(ACT_DELETE, -5, 0);
    queue_cap(5'd0);
    queue_cmd(ACT_PUT, 1, 0);
    queue_cap(5'd31);
    queue_cmd(ACT_PUT, 32'haaaa_aaaa, 0);
    queue_cmd(ACT_PUT, 32'h5555_5555, 0);

    made  = 0;
    phase = 0;
    while (made < RANDOM_ITEMS) begin
      case (phase % 6)
        0:       cap = 5'd16;
        1:       cap = 5'($urandom_range(1, 15));
        2:       cap = 5'd1;
        3:       cap = 5'($urandom_range(17, 31));
        4:       cap = 5'd0;
        default: cap = 5'd31;
      endcase
      queue_cap(cap);
      plen     = (cap == 0) ? 20 : $urandom_range(60, 140);
      if (plen > RANDOM_ITEMS - made) plen = RANDOM_ITEMS - made;
      put_pct  = $urandom_range(45, 80);
      gap_mode = $urandom_range(0, 2);
      for (int k = 0; k < 6; k++) begin
        case (k % 3)
          0: pool[k] = $urandom;
          1: pool[k] = int'($urandom_range(0, 16)) - 8;
          default: begin
            case ($urandom_range(0, 3))
              0: pool[k] = 32'h8000_0000;
              1: pool[k] = 32'h7fff_ffff;
              2: pool[k] = 0;
              default: pool[k] = -1;
            endcase
          end
        endcase
      end
      for (int i = 0; i < plen; i++) begin
        r = $urandom_range(0, 99);
        if (r < put_pct) act = ACT_PUT;
        else if (r < 94) act = ACT_DELETE;
        else if (r < 97) act = ACT_CLEAR;
        else act = ACT_UNUSED;
        v = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 5)] : $urandom;
        case (gap_mode)
          0:       gap = 0;
          1:       gap = $urandom_range(0, 18);
          default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
        endcase
        // hold until every owed report is in
        if (i == plen / 2) queue_drain();
        queue_cmd(act, v, gap);
      end
      made += plen;
      phase++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_steps.size() > 0 || n_accepted != n_launched || owed_reports.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands: %0d put, %0d delete, %0d clear, %0d unused code;",
             n_accepted, n_by_action[0], n_by_action[1], n_by_action[2], n_by_action[3]);
    $display("%0d capacity writes, %0d store-full, %0d store-empty, peak count %0d",
             n_cap_writes, n_full, n_empty, peak_count);
    if (n_mismatch == 0 && owed_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
